// ===== rtl/core/swcb_pkg.sv =====
// ============================================================================
// swcb_pkg
// Shared types and constants of the sliding-window circuit breaker.
// ============================================================================
package swcb_pkg;

    // Sizing of the outcome window and of the time base.
    localparam int WINDOW_MAX = 64;
    localparam int TIME_BITS  = 48;
    localparam int CNT_W      = $clog2(WINDOW_MAX + 1);
    localparam int HEAD_W     = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

    // Field and register widths.
    localparam int CMD_W      = 2;
    localparam int STATE_W    = 2;
    localparam int WLEN_W     = 7;
    localparam int MINS_W     = 7;
    localparam int RATIO_W    = 17;
    localparam int Q16_W      = 16;
    localparam int PROBE_W    = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam int PRODUCT_W  = RATIO_W + CNT_W;

    localparam logic [PROBE_W-1:0] PROBE_MAX = {PROBE_W{1'b1}};

    // Breaker states as reported on the result.
    typedef enum logic [STATE_W-1:0] {
        MODE_CLOSED = 2'd0,
        MODE_OPEN   = 2'd1,
        MODE_HALF   = 2'd2
    } t_mode;

    // Item commands.
    typedef enum logic [CMD_W-1:0] {
        CMD_REQUEST = 2'd0,
        CMD_SUCCESS = 2'd1,
        CMD_FAILURE = 2'd2
    } t_cmd;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_LENGTH = 3'd0,
        CFG_MIN_SAMPLES   = 3'd1,
        CFG_TRIP_RATIO    = 3'd2,
        CFG_OPEN_TIMEOUT  = 3'd3,
        CFG_PROBE_QUOTA   = 3'd4
    } t_cfg_idx;

    // Window control from the state machine.
    typedef struct packed {
        logic push;
        logic failed;
        logic clear;
    } t_win_ctrl;

    // Window counts after the current step.
    typedef struct packed {
        logic [CNT_W-1:0] failures;
        logic [CNT_W-1:0] samples;
    } t_win_stat;

endpackage

// ===== rtl/core/sliding_window_circuit_breaker_top.sv =====
// ============================================================================
// sliding_window_circuit_breaker_top
// Count-based sliding-window circuit breaker with valid/ready channels.
// ============================================================================
// Each input item carries a command (request, success report, failure
// report) and a timestamp; each item yields exactly one result item with the
// grant, the breaker state after the step and the window counts.
// Input items are taken into an input register, processed by
// the state machine and window logic, and written to an output register.
// An item leaves the input register and its result enters the output
// register at the same clock edge, once the output register is free or drained.
// Throughput: one item per cycle while the receiver does not stall.
// While the receiver stalls, the result holds in the output register and
// one more item may wait in the input register; o_in_ready then drops.
// Reset (synchronous, active low) sets the breaker closed, clears the window
// and probe counters and loads the default configuration.
// Configuration writes (i_cfg_we, i_cfg_idx, i_cfg_data) take effect at
// once; the user must issue them only while no item is in flight, as the
// block does not enforce it. A window length write also clears the window.
// ============================================================================
module sliding_window_circuit_breaker_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration port
    input  logic                                i_cfg_we,
    input  logic [swcb_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [swcb_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // Input channel
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [swcb_pkg::CMD_W-1:0]          i_cmd,
    input  logic [swcb_pkg::TIME_BITS-1:0]      i_now,
    // Output channel
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_granted,
    output logic [swcb_pkg::STATE_W-1:0]        o_breaker_state,
    output logic [swcb_pkg::CNT_W-1:0]          o_window_failures,
    output logic [swcb_pkg::CNT_W-1:0]          o_window_samples
);

    // Configuration registers.
    logic [swcb_pkg::WLEN_W-1:0]    r_window_length;
    logic [swcb_pkg::MINS_W-1:0]    r_min_samples;
    logic [swcb_pkg::RATIO_W-1:0]   r_trip_ratio;
    logic [swcb_pkg::TIME_BITS-1:0] r_open_timeout;
    logic [swcb_pkg::PROBE_W-1:0]   r_probe_quota;
    logic                           cfg_clear;

    // Input register.
    logic                           r_in_valid;
    logic [swcb_pkg::CMD_W-1:0]     r_in_cmd;
    logic [swcb_pkg::TIME_BITS-1:0] r_in_now;
    logic                           fire;

    // Output register.
    logic                           r_out_valid;
    logic                           r_granted;
    swcb_pkg::t_mode                r_state;
    logic [swcb_pkg::CNT_W-1:0]     r_failures;
    logic [swcb_pkg::CNT_W-1:0]     r_samples;

    swcb_pkg::t_win_ctrl            win_ctrl;
    swcb_pkg::t_win_stat            win_next;
    logic                           granted;
    swcb_pkg::t_mode                mode_next;

    // Configuration writes; indexes past the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_length <= swcb_pkg::WLEN_W'(64);
            r_min_samples   <= swcb_pkg::MINS_W'(10);
            r_trip_ratio    <= swcb_pkg::RATIO_W'(32768);
            r_open_timeout  <= swcb_pkg::TIME_BITS'(1000000);
            r_probe_quota   <= swcb_pkg::PROBE_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                swcb_pkg::CFG_WINDOW_LENGTH:
                    r_window_length <= i_cfg_data[swcb_pkg::WLEN_W-1:0];
                swcb_pkg::CFG_MIN_SAMPLES:
                    r_min_samples <= i_cfg_data[swcb_pkg::MINS_W-1:0];
                swcb_pkg::CFG_TRIP_RATIO:
                    r_trip_ratio <= i_cfg_data[swcb_pkg::RATIO_W-1:0];
                swcb_pkg::CFG_OPEN_TIMEOUT:
                    r_open_timeout <= i_cfg_data[swcb_pkg::TIME_BITS-1:0];
                swcb_pkg::CFG_PROBE_QUOTA:
                    r_probe_quota <= i_cfg_data[swcb_pkg::PROBE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign cfg_clear = i_cfg_we && (i_cfg_idx == swcb_pkg::CFG_WINDOW_LENGTH);

    // An item is processed when the output register is free or being drained.
    assign fire       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || fire;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_cmd <= i_cmd;
            r_in_now <= i_now;
        end
    end

    swcb_fsm u_fsm (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (fire),
        .i_cmd          (r_in_cmd),
        .i_now          (r_in_now),
        .i_cfg_clear    (cfg_clear),
        .i_min_samples  (r_min_samples),
        .i_trip_ratio   (r_trip_ratio),
        .i_open_timeout (r_open_timeout),
        .i_probe_quota  (r_probe_quota),
        .i_win_next     (win_next),
        .o_win_ctrl     (win_ctrl),
        .o_granted      (granted),
        .o_mode         (mode_next)
    );

    swcb_window u_window (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctrl          (win_ctrl),
        .i_window_length (r_window_length),
        .o_next          (win_next)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_granted  <= granted;
            r_state    <= mode_next;
            r_failures <= win_next.failures;
            r_samples  <= win_next.samples;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_granted         = r_granted;
    assign o_breaker_state   = r_state;
    assign o_window_failures = r_failures;
    assign o_window_samples  = r_samples;

    // The window never reports more failures than samples.
    a_fail_le_samples: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_window_failures <= o_window_samples))
        else $error("window failures exceed samples");

    // A result that leaves the breaker open never carries a grant.
    a_open_no_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_breaker_state == swcb_pkg::MODE_OPEN)) |-> !o_granted)
        else $error("grant reported while open");

    // The window never holds more samples than its maximum length.
    a_samples_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (int'(o_window_samples) <= swcb_pkg::WINDOW_MAX))
        else $error("window samples above maximum");

    // An accepted item is held in the input register on the next cycle.
    a_in_captured: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_in_valid)
        else $error("accepted item lost");

endmodule

// ===== rtl/core/swcb_window.sv =====
// ============================================================================
// swcb_window
// Ring of recent pass/fail outcomes with sample and failure counters.
// ============================================================================
module swcb_window (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  swcb_pkg::t_win_ctrl                 i_ctrl,
    input  logic [swcb_pkg::WLEN_W-1:0]         i_window_length,
    output swcb_pkg::t_win_stat                 o_next
);

    logic [swcb_pkg::HEAD_W-1:0] r_head;
    logic [swcb_pkg::HEAD_W-1:0] n_head;
    logic [swcb_pkg::CNT_W-1:0]  r_samples;
    logic [swcb_pkg::CNT_W-1:0]  n_samples;
    logic [swcb_pkg::CNT_W-1:0]  r_fails;
    logic [swcb_pkg::CNT_W-1:0]  n_fails;
    logic [swcb_pkg::CNT_W-1:0]  eff_len;
    logic                        full;
    logic                        drop;
    logic                        wrap;

    // Outcome memory and the registered read of the entry at the head.
    logic                        r_ring [swcb_pkg::WINDOW_MAX];
    logic                        r_rd;

    // Effective window length: zero acts as one, the top saturates.
    always_comb begin
        if (i_window_length == '0) begin
            eff_len = swcb_pkg::CNT_W'(1);
        end else if (int'(i_window_length) > swcb_pkg::WINDOW_MAX) begin
            eff_len = swcb_pkg::CNT_W'(swcb_pkg::WINDOW_MAX);
        end else begin
            eff_len = swcb_pkg::CNT_W'(i_window_length);
        end
    end

    // Push one outcome: evict the oldest once the window is full.
    // The oldest entry is only read once every slot below the length has
    // been written since the last clear, so the ring itself needs no reset.
    always_comb begin
        full = (r_samples >= eff_len);
        drop = i_ctrl.push && full && r_rd && (r_fails != '0);
        wrap = ((swcb_pkg::CNT_W'(r_head) + swcb_pkg::CNT_W'(1)) >= eff_len);

        n_head    = r_head;
        n_samples = r_samples;
        n_fails   = r_fails;
        if (i_ctrl.clear) begin
            n_head    = '0;
            n_samples = '0;
            n_fails   = '0;
        end else if (i_ctrl.push) begin
            n_head    = wrap ? '0 : r_head + swcb_pkg::HEAD_W'(1);
            n_samples = full ? r_samples : r_samples + swcb_pkg::CNT_W'(1);
            n_fails   = r_fails - swcb_pkg::CNT_W'(drop)
                        + swcb_pkg::CNT_W'(i_ctrl.failed);
        end
    end

    assign o_next.failures = n_fails;
    assign o_next.samples  = n_samples;

    // Head and counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_samples <= '0;
            r_fails   <= '0;
        end else begin
            r_head    <= n_head;
            r_samples <= n_samples;
            r_fails   <= n_fails;
        end
    end

    // Ring write at the head and read-ahead of the next head entry.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.push && !i_ctrl.clear) begin
            r_ring[r_head] <= i_ctrl.failed;
            if (n_head == r_head) begin
                r_rd <= i_ctrl.failed;
            end else begin
                r_rd <= r_ring[n_head];
            end
        end
    end

endmodule

// ===== rtl/core/swcb_fsm.sv =====
// ============================================================================
// swcb_fsm
// Breaker state machine: grants, trip test, open timeout and probing.
// ============================================================================
module swcb_fsm (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_fire,
    input  logic [swcb_pkg::CMD_W-1:0]          i_cmd,
    input  logic [swcb_pkg::TIME_BITS-1:0]      i_now,
    input  logic                                i_cfg_clear,
    input  logic [swcb_pkg::MINS_W-1:0]         i_min_samples,
    input  logic [swcb_pkg::RATIO_W-1:0]        i_trip_ratio,
    input  logic [swcb_pkg::TIME_BITS-1:0]      i_open_timeout,
    input  logic [swcb_pkg::PROBE_W-1:0]        i_probe_quota,
    input  swcb_pkg::t_win_stat                 i_win_next,
    output swcb_pkg::t_win_ctrl                 o_win_ctrl,
    output logic                                o_granted,
    output swcb_pkg::t_mode                     o_mode
);

    swcb_pkg::t_mode                r_mode;
    swcb_pkg::t_mode                n_mode;
    logic [swcb_pkg::TIME_BITS-1:0] r_opened;
    logic [swcb_pkg::TIME_BITS-1:0] n_opened;
    logic [swcb_pkg::PROBE_W-1:0]   r_sent;
    logic [swcb_pkg::PROBE_W-1:0]   n_sent;
    logic [swcb_pkg::PROBE_W-1:0]   r_passed;
    logic [swcb_pkg::PROBE_W-1:0]   n_passed;
    logic [swcb_pkg::PROBE_W-1:0]   passed_inc;
    logic [swcb_pkg::TIME_BITS-1:0] elapsed;
    logic [swcb_pkg::PRODUCT_W-1:0] lhs;
    logic [swcb_pkg::PRODUCT_W-1:0] rhs;
    logic                           ratio_hit;

    // Failure ratio test on the counts after this push, by cross-multiplying.
    always_comb begin
        lhs = {{(swcb_pkg::PRODUCT_W - swcb_pkg::CNT_W - swcb_pkg::Q16_W){1'b0}},
               i_win_next.failures, {swcb_pkg::Q16_W{1'b0}}};
        rhs = swcb_pkg::PRODUCT_W'(i_trip_ratio) * swcb_pkg::PRODUCT_W'(i_win_next.samples);
        if (swcb_pkg::CNT_W'(i_min_samples) > i_win_next.samples
                || (swcb_pkg::CNT_W < swcb_pkg::MINS_W
                    && int'(i_min_samples) > swcb_pkg::WINDOW_MAX)) begin
            ratio_hit = (i_trip_ratio == '0);
        end else begin
            ratio_hit = (lhs >= rhs);
        end
    end

    // Open time, modulo the time base, and the saturating probe success count.
    assign elapsed    = i_now - r_opened;
    assign passed_inc = (r_passed == swcb_pkg::PROBE_MAX) ? r_passed
                                                          : r_passed + swcb_pkg::PROBE_W'(1);

    // Next state, grant and window control.
    always_comb begin
        n_mode            = r_mode;
        n_opened          = r_opened;
        n_sent            = r_sent;
        n_passed          = r_passed;
        o_granted         = 1'b0;
        o_win_ctrl.push   = 1'b0;
        o_win_ctrl.failed = 1'b0;
        o_win_ctrl.clear  = i_cfg_clear;
        if (i_fire) begin
            case (i_cmd)
                swcb_pkg::CMD_REQUEST: begin
                    case (r_mode)
                        swcb_pkg::MODE_CLOSED: begin
                            o_granted = 1'b1;
                        end
                        swcb_pkg::MODE_OPEN: begin
                            if (elapsed >= i_open_timeout) begin
                                n_mode    = swcb_pkg::MODE_HALF;
                                n_sent    = swcb_pkg::PROBE_W'(1);
                                n_passed  = '0;
                                o_granted = 1'b1;
                            end
                        end
                        default: begin
                            if (r_sent < i_probe_quota) begin
                                n_sent    = r_sent + swcb_pkg::PROBE_W'(1);
                                o_granted = 1'b1;
                            end
                        end
                    endcase
                end
                swcb_pkg::CMD_SUCCESS: begin
                    if (r_mode == swcb_pkg::MODE_CLOSED) begin
                        o_win_ctrl.push = 1'b1;
                    end else if (r_mode == swcb_pkg::MODE_HALF) begin
                        n_passed = passed_inc;
                        if (passed_inc >= i_probe_quota) begin
                            n_mode           = swcb_pkg::MODE_CLOSED;
                            o_win_ctrl.clear = 1'b1;
                        end
                    end
                end
                swcb_pkg::CMD_FAILURE: begin
                    if (r_mode == swcb_pkg::MODE_CLOSED) begin
                        o_win_ctrl.push   = 1'b1;
                        o_win_ctrl.failed = 1'b1;
                        if (ratio_hit) begin
                            n_mode   = swcb_pkg::MODE_OPEN;
                            n_opened = i_now;
                        end
                    end else if (r_mode == swcb_pkg::MODE_HALF) begin
                        n_mode   = swcb_pkg::MODE_OPEN;
                        n_opened = i_now;
                    end
                end
                default: begin
                    // The unused command leaves everything as it is.
                end
            endcase
        end
    end

    assign o_mode = n_mode;

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= swcb_pkg::MODE_CLOSED;
            r_opened <= '0;
            r_sent   <= '0;
            r_passed <= '0;
        end else begin
            r_mode   <= n_mode;
            r_opened <= n_opened;
            r_sent   <= n_sent;
            r_passed <= n_passed;
        end
    end

endmodule

// ===== bench/breaker_checker.sv =====
// ============================================================================
// breaker_checker
// Watches the item channels and configuration writes of the circuit breaker,
// keeps its own model of the breaker state and window, and compares every
// result item with the prediction made when its input item was taken.
// ============================================================================
`timescale 1ns / 1ps

module breaker_checker
    import swcb_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_in_valid,
    input  logic                   i_in_ready,
    input  logic [CMD_W-1:0]       i_cmd,
    input  logic [TIME_BITS-1:0]   i_now,
    input  logic                   i_out_valid,
    input  logic                   i_out_ready,
    input  logic                   i_granted,
    input  logic [STATE_W-1:0]     i_breaker_state,
    input  logic [CNT_W-1:0]       i_window_failures,
    input  logic [CNT_W-1:0]       i_window_samples,
    output int                     o_pending,
    output int                     o_mismatches
);

    // Register values after reset.
    localparam logic [WLEN_W-1:0]    DEF_WINDOW  = 7'd64;
    localparam logic [MINS_W-1:0]    DEF_MINS    = 7'd10;
    localparam logic [RATIO_W-1:0]   DEF_RATIO   = 17'd32768;
    localparam logic [TIME_BITS-1:0] DEF_TIMEOUT = 48'd1000000;
    localparam logic [PROBE_W-1:0]   DEF_QUOTA   = 8'd1;
    localparam logic [63:0]          Q16_ONE     = 64'd1 << Q16_W;

    // One result item as the breaker should report it.
    typedef struct packed {
        logic             granted;
        t_mode            state;
        logic [CNT_W-1:0] failures;
        logic [CNT_W-1:0] samples;
    } t_verdict;

    t_verdict verdicts_due[$];

    // Shadow configuration.
    logic [WLEN_W-1:0]    cfg_window;
    logic [MINS_W-1:0]    cfg_mins;
    logic [RATIO_W-1:0]   cfg_ratio;
    logic [TIME_BITS-1:0] cfg_timeout;
    logic [PROBE_W-1:0]   cfg_quota;

    // Shadow breaker state.
    t_mode                brk_mode;
    logic [TIME_BITS-1:0] open_stamp;
    logic [PROBE_W-1:0]   probes_out;
    logic [PROBE_W-1:0]   probes_ok;
    logic [WINDOW_MAX-1:0] outcomes;
    int unsigned          head;
    int unsigned          n_samples;
    int unsigned          n_failures;

    task automatic report(input string msg);
        o_mismatches++;
        $display("%0t ns breaker_checker: %s", $time, msg);
    endtask

    // A window length of zero behaves as one; oversized lengths are clipped.
    function automatic int unsigned window_span();
        if (cfg_window == 0) return 1;
        if (cfg_window > WINDOW_MAX) return WINDOW_MAX;
        return cfg_window;
    endfunction

    task automatic clear_window();
        outcomes   = '0;
        head       = 0;
        n_samples  = 0;
        n_failures = 0;
    endtask

    // Write one outcome into the ring, evicting the oldest once full.
    task automatic push_outcome(input bit failed);
        int unsigned span;
        span = window_span();
        if (head >= span) head = 0;
        if (n_samples >= span && outcomes[head] && n_failures > 0) n_failures--;
        outcomes[head] = failed;
        if (failed) n_failures++;
        head = (head + 1 >= span) ? 0 : head + 1;
        if (n_samples < span) n_samples++;
    endtask

    // Exact ratio test by cross-multiplication; below the sample floor the
    // ratio counts as zero.
    function automatic bit ratio_reached();
        logic [63:0] lhs;
        logic [63:0] rhs;
        if (n_samples < cfg_mins) return cfg_ratio == 0;
        lhs = 64'(n_failures) * Q16_ONE;
        rhs = 64'(cfg_ratio) * 64'(n_samples);
        return lhs >= rhs;
    endfunction

    task automatic open_breaker(input logic [TIME_BITS-1:0] now);
        brk_mode   = MODE_OPEN;
        open_stamp = now;
    endtask

    // Advance the breaker by one command and return the result it reports.
    task automatic step_breaker(input logic [CMD_W-1:0] cmd,
                                input logic [TIME_BITS-1:0] now,
                                output t_verdict verdict);
        logic                 granted;
        logic [TIME_BITS-1:0] elapsed;
        granted = 1'b0;
        case (cmd)
            CMD_REQUEST: begin
                case (brk_mode)
                    MODE_CLOSED: granted = 1'b1;
                    MODE_OPEN: begin
                        elapsed = now - open_stamp;
                        if (elapsed >= cfg_timeout) begin
                            brk_mode   = MODE_HALF;
                            probes_out = 8'd1;
                            probes_ok  = '0;
                            granted    = 1'b1;
                        end
                    end
                    default: begin
                        if (probes_out < cfg_quota) begin
                            probes_out++;
                            granted = 1'b1;
                        end
                    end
                endcase
            end
            CMD_SUCCESS: begin
                if (brk_mode == MODE_CLOSED) begin
                    push_outcome(1'b0);
                end else if (brk_mode == MODE_HALF) begin
                    if (probes_ok < PROBE_MAX) probes_ok++;
                    if (probes_ok >= cfg_quota) begin
                        brk_mode = MODE_CLOSED;
                        clear_window();
                    end
                end
            end
            CMD_FAILURE: begin
                if (brk_mode == MODE_CLOSED) begin
                    push_outcome(1'b1);
                    if (ratio_reached()) open_breaker(now);
                end else if (brk_mode == MODE_HALF) begin
                    open_breaker(now);
                end
            end
            default: ;
        endcase
        verdict.granted  = granted;
        verdict.state    = brk_mode;
        verdict.failures = CNT_W'(n_failures);
        verdict.samples  = CNT_W'(n_samples);
    endtask

    // Track writes, predict on each accepted input item and check each
    // accepted result item against the oldest prediction.
    always @(posedge i_clk) begin
        t_verdict want;
        t_verdict fresh;
        if (!i_rst_n) begin
            cfg_window   = DEF_WINDOW;
            cfg_mins     = DEF_MINS;
            cfg_ratio    = DEF_RATIO;
            cfg_timeout  = DEF_TIMEOUT;
            cfg_quota    = DEF_QUOTA;
            brk_mode     = MODE_CLOSED;
            open_stamp   = '0;
            probes_out   = '0;
            probes_ok    = '0;
            clear_window();
            verdicts_due.delete();
            o_mismatches = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_WINDOW_LENGTH: begin
                        cfg_window = i_cfg_data[WLEN_W-1:0];
                        clear_window();
                    end
                    CFG_MIN_SAMPLES:  cfg_mins    = i_cfg_data[MINS_W-1:0];
                    CFG_TRIP_RATIO:   cfg_ratio   = i_cfg_data[RATIO_W-1:0];
                    CFG_OPEN_TIMEOUT: cfg_timeout = i_cfg_data[TIME_BITS-1:0];
                    CFG_PROBE_QUOTA:  cfg_quota   = i_cfg_data[PROBE_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (verdicts_due.size() == 0) begin
                    report("result item with no prediction waiting");
                end else begin
                    want = verdicts_due.pop_front();
                    if (i_granted !== want.granted)
                        report($sformatf("granted: got %0d, predicted %0d",
                                         i_granted, want.granted));
                    if (i_breaker_state !== want.state)
                        report($sformatf("breaker_state: got %0d, predicted %0d",
                                         i_breaker_state, want.state));
                    if (i_window_failures !== want.failures)
                        report($sformatf("window_failures: got %0d, predicted %0d",
                                         i_window_failures, want.failures));
                    if (i_window_samples !== want.samples)
                        report($sformatf("window_samples: got %0d, predicted %0d",
                                         i_window_samples, want.samples));
                end
            end
            if (i_in_valid && i_in_ready) begin
                step_breaker(i_cmd, i_now, fresh);
                verdicts_due.push_back(fresh);
            end
        end
        o_pending = verdicts_due.size();
    end

endmodule

// ===== bench/tb.sv =====
// ============================================================================
// tb
// Stimulus and verdict for the sliding-window circuit breaker.
// ============================================================================
// A directed opening walks the breaker through every command, the window
// length, sample floor and ratio extremes, the longest open timeout and the
// zero probe quota. Random phases then reprogram the registers and send
// request/outcome pairs on a running clock, mixed with stray commands and
// time jumps, while both channels idle at random.
// ============================================================================
`timescale 1ns / 1ps

module tb;
    import swcb_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 4;
    localparam int STALL_LIMIT   = 2000;
    localparam int GAP_MAX       = 16;
    localparam int SETTLE_CYCLES = 6;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS   = 135;

    localparam logic [CMD_W-1:0]     CMD_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam logic [TIME_BITS-1:0] TIME_TOP   = '1;
    localparam logic [TIME_BITS-1:0] TIME_MID   = 48'h8000_0000_0000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [CMD_W-1:0]      i_cmd = '0;
    logic [TIME_BITS-1:0]  i_now = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic                  o_granted;
    logic [STATE_W-1:0]    o_breaker_state;
    logic [CNT_W-1:0]      o_window_failures;
    logic [CNT_W-1:0]      o_window_samples;

    int pending;
    int mismatches;
    int idle_cycles;
    int tx_left;
    bit tx_calm;

    sliding_window_circuit_breaker_top i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_cmd             (i_cmd),
        .i_now             (i_now),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_granted         (o_granted),
        .o_breaker_state   (o_breaker_state),
        .o_window_failures (o_window_failures),
        .o_window_samples  (o_window_samples)
    );

    breaker_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .i_in_ready        (o_in_ready),
        .i_cmd             (i_cmd),
        .i_now             (i_now),
        .i_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .i_granted         (o_granted),
        .i_breaker_state   (o_breaker_state),
        .i_window_failures (o_window_failures),
        .i_window_samples  (o_window_samples),
        .o_pending         (pending),
        .o_mismatches      (mismatches)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Stall watchdog: any item, result or register write counts as progress.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
            || i_cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Gaps come in stretches: some stretches run back to back, others idle
    // for a random gap before each item.
    function automatic int draw_gap(inout int left, inout bit calm);
        if (left == 0) begin
            left = $urandom_range(20, 80);
            calm = ($urandom_range(0, 2) == 0);
        end
        left--;
        return calm ? 0 : $urandom_range(0, GAP_MAX);
    endfunction

    function automatic logic [TIME_BITS-1:0] rand_time();
        return TIME_BITS'({$urandom, $urandom});
    endfunction

    // Register data with random bits above the register's own width.
    function automatic logic [CFG_DATA_W-1:0] with_junk(input logic [CFG_DATA_W-1:0] value,
                                                       input int width);
        logic [CFG_DATA_W-1:0] junk;
        junk = rand_time();
        return (junk << width) | value;
    endfunction

    // Result side: hold ready low for a drawn gap, then keep it high until a
    // result item is taken.
    initial begin
        int  gap;
        int  rx_left;
        bit  rx_calm;
        rx_left = 0;
        rx_calm = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            gap = draw_gap(rx_left, rx_calm);
            if (gap != 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    // Offer one input item after a drawn gap; returns on the falling edge
    // after it was taken, with valid still high.
    task automatic send_item(input logic [CMD_W-1:0] cmd,
                             input logic [TIME_BITS-1:0] stamp);
        int gap;
        gap = draw_gap(tx_left, tx_calm);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd      <= cmd;
        i_now      <= stamp;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Stop offering items and let every result drain before touching registers.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
    endtask

    initial begin
        logic [TIME_BITS-1:0] clock;
        logic [TIME_BITS-1:0] timeout;
        logic [63:0]          step_max;
        logic [63:0]          advance;
        logic [WLEN_W-1:0]    wlen;
        logic [MINS_W-1:0]    mins;
        logic [RATIO_W-1:0]   ratio;
        logic [PROBE_W-1:0]   quota;
        logic [CMD_W-1:0]     cmd;
        int                   fail_pct;
        int                   sent;

        tx_left = 0;
        tx_calm = 1'b0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Default registers: every command, a stray code and the time extremes.
        send_item(CMD_REQUEST, '0);
        send_item(CMD_UNUSED, TIME_TOP);
        send_item(CMD_SUCCESS, TIME_TOP);
        send_item(CMD_FAILURE, 48'd1);

        // Zero window length acts as one, zero sample floor and zero ratio
        // trip on any failure, longest timeout, zero probe quota. Reports
        // while open are dropped; the entry probe is granted even with no
        // quota, the next request is refused, and one success closes.
        settle();
        write_reg(CFG_WINDOW_LENGTH, '0);
        write_reg(CFG_MIN_SAMPLES, '0);
        write_reg(CFG_TRIP_RATIO, '0);
        write_reg(CFG_PROBE_QUOTA, '0);
        write_reg(CFG_OPEN_TIMEOUT, TIME_TOP);
        write_reg(CFG_UNUSED, TIME_TOP);
        i_cfg_we <= 1'b0;
        send_item(CMD_SUCCESS, 48'd10);
        send_item(CMD_FAILURE, TIME_MID);
        send_item(CMD_SUCCESS, TIME_MID + 48'd1);
        send_item(CMD_FAILURE, TIME_MID + 48'd1);
        send_item(CMD_REQUEST, TIME_MID + 48'd2);
        send_item(CMD_REQUEST, TIME_MID - 48'd1);
        send_item(CMD_REQUEST, TIME_MID);
        send_item(CMD_SUCCESS, TIME_MID);

        // Oversized window, sample floor above the window and a ratio above
        // one: failures never trip.
        settle();
        write_reg(CFG_WINDOW_LENGTH, 48'd127);
        write_reg(CFG_MIN_SAMPLES, 48'd127);
        write_reg(CFG_TRIP_RATIO, 48'd131071);
        write_reg(CFG_PROBE_QUOTA, 48'd255);
        write_reg(CFG_OPEN_TIMEOUT, '0);
        i_cfg_we <= 1'b0;
        repeat (3) send_item(CMD_FAILURE, 48'd100);
        settle();
        write_reg(CFG_MIN_SAMPLES, '0);
        i_cfg_we <= 1'b0;
        send_item(CMD_FAILURE, 48'd101);

        // Ratio of exactly one trips on an all-failure window; zero timeout
        // goes half-open at once; a probe failure reopens.
        settle();
        write_reg(CFG_TRIP_RATIO, 48'd65536);
        i_cfg_we <= 1'b0;
        send_item(CMD_FAILURE, 48'd102);
        send_item(CMD_REQUEST, 48'd102);
        send_item(CMD_REQUEST, 48'd103);
        send_item(CMD_FAILURE, 48'd104);
        send_item(CMD_REQUEST, 48'd104);
        send_item(CMD_SUCCESS, 48'd105);
        settle();
        write_reg(CFG_PROBE_QUOTA, 48'd1);
        i_cfg_we <= 1'b0;
        send_item(CMD_SUCCESS, 48'd106);

        // Random phases: new settings, then request/outcome traffic.
        clock = 48'd200;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            settle();
            case ($urandom_range(0, 7))
                0: wlen = '0;
                1: wlen = 7'd127;
                2: wlen = 7'd64;
                3: wlen = 7'd1;
                default: wlen = WLEN_W'($urandom_range(2, 20));
            endcase
            case ($urandom_range(0, 5))
                0: mins = '0;
                1: mins = 7'd127;
                2: mins = 7'd64;
                default: mins = MINS_W'($urandom_range(0, 12));
            endcase
            case ($urandom_range(0, 7))
                0: ratio = '0;
                1: ratio = 17'd65536;
                2: ratio = 17'd131071;
                3: ratio = RATIO_W'($urandom_range(65537, 131071));
                default: ratio = RATIO_W'($urandom_range(1, 65535));
            endcase
            case ($urandom_range(0, 7))
                0: timeout = '0;
                1: timeout = TIME_TOP;
                2: timeout = 48'd1000000;
                default: timeout = TIME_BITS'($urandom_range(1, 300));
            endcase
            case ($urandom_range(0, 7))
                0: quota = '0;
                1: quota = 8'd255;
                2: quota = 8'd1;
                default: quota = PROBE_W'($urandom_range(2, 6));
            endcase
            if (phase == 0 || $urandom_range(0, 3) != 0)
                write_reg(CFG_WINDOW_LENGTH, with_junk(48'(wlen), WLEN_W));
            if (phase == 0 || $urandom_range(0, 3) != 0)
                write_reg(CFG_MIN_SAMPLES, with_junk(48'(mins), MINS_W));
            if (phase == 0 || $urandom_range(0, 3) != 0)
                write_reg(CFG_TRIP_RATIO, with_junk(48'(ratio), RATIO_W));
            if (phase == 0 || $urandom_range(0, 3) != 0)
                write_reg(CFG_OPEN_TIMEOUT, timeout);
            if (phase == 0 || $urandom_range(0, 3) != 0)
                write_reg(CFG_PROBE_QUOTA, with_junk(48'(quota), PROBE_W));
            i_cfg_we <= 1'b0;

            // Time steps scale with the timeout; some phases start near the wrap.
            step_max = 64'(timeout >> 3) + 64'd1;
            fail_pct = $urandom_range(5, 95);
            if ($urandom_range(0, 3) == 0) clock = TIME_TOP - TIME_BITS'($urandom_range(0, 500));
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                if ($urandom_range(0, 99) < 12) begin
                    // Stray item: any code, sometimes at an unrelated time.
                    cmd = CMD_W'($urandom_range(0, 3));
                    send_item(cmd, ($urandom_range(0, 3) == 0) ? rand_time() : clock);
                    sent++;
                end else begin
                    if ($urandom_range(0, 39) == 0) clock = rand_time();
                    advance = {$urandom, $urandom} % (step_max + 64'd1);
                    clock = clock + advance[TIME_BITS-1:0];
                    send_item(CMD_REQUEST, clock);
                    clock = clock + TIME_BITS'($urandom_range(0, 3));
                    cmd = ($urandom_range(0, 99) < fail_pct) ? CMD_FAILURE : CMD_SUCCESS;
                    send_item(cmd, clock);
                    sent += 2;
                end
            end
        end

        settle();
        if (mismatches == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
